### design/inverse_cdf_interpolating_lookup_defines.svh
// Assertion helpers for the checker file of the lookup block.
// Each macro expands to one labeled concurrent assertion clocked on i_clk
// and held off while i_rst_n is low.
`ifndef INVERSE_CDF_INTERPOLATING_LOOKUP_DEFINES_SVH
`define INVERSE_CDF_INTERPOLATING_LOOKUP_DEFINES_SVH

// Same-cycle implication.
`define ICDF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icdf: same-cycle check failed");

// Next-cycle implication.
`define ICDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icdf: next-cycle check failed");

`endif

### design/icdf_pkg.sv
`default_nettype none

package icdf_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int TABLE_SIZE_W    = 9;
    localparam int INDEX_W         = 8;
    localparam int CDF_W           = 32;
    localparam int VALUE_W         = 32;
    localparam int PROD_W          = CDF_W + VALUE_W;

    // Serial divider: quotient bits retired per cycle
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = PROD_W / DIV_BITS;

    // Stream packing
    localparam int S_FIELDS_W  = INDEX_W + CDF_W + VALUE_W + CDF_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_IDX_LSB   = 0;
    localparam int S_ECDF_LSB  = S_IDX_LSB + INDEX_W;
    localparam int S_EVAL_LSB  = S_ECDF_LSB + CDF_W;
    localparam int S_QCDF_LSB  = S_EVAL_LSB + VALUE_W;
    localparam int M_FIELDS_W  = VALUE_W + INDEX_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_VAL_LSB   = 0;
    localparam int M_LIDX_LSB  = M_VAL_LSB + VALUE_W;
    localparam int STATUS_W    = 2;

    // Configuration registers
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = TABLE_SIZE_W;
    localparam logic [CFG_IDX_W-1:0]    CFG_TABLE_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]    CFG_INTERPOLATE = CFG_IDX_W'(1);
    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST  = TABLE_SIZE_W'(2);
    localparam logic                    INTERP_RST      = 1'b1;

    // Request kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EQUAL = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_RD_HI,
        S_CAP_HI,
        S_DIFF,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        ADDR_MID,
        ADDR_LO,
        ADDR_HI
    } t_addr_sel;

    typedef struct packed {
        logic      capture;
        logic      mem_write;
        t_addr_sel addr_sel;
        logic      search_cmp;
        logic      cap_lo;
        logic      cap_hi;
        logic      diff;
        logic      mul;
        logic      div_start;
        logic      finish;
        logic      push;
    } t_dp_cmd;

    typedef struct packed {
        logic in_query;
        logic search_more;
        logic use_math;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### design/inverse_cdf_interpolating_lookup.sv
`default_nettype none

// Inverse-CDF lookup with optional linear interpolation. A request with
// mode 0 (load) writes one table entry and returns an all-zero result; a
// request with mode 1 (query) binary-searches the first table_size entries
// (clamped to 2..TABLE_DEPTH) for the interval bracketing query_cdf and
// returns the lower entry's value or the interpolated value, with status 1
// for equal bracketing CDFs and 2 for a saturated result. Every request
// returns exactly one result. The block handles one request at a time. A
// query makes at most ceil(log2(n - 1)) search steps for n entries in use
// (8 for a 256-entry table); each step is one table read plus one compare,
// since the CDF table has a single registered read port. Interpolation with
// unequal bracketing CDFs adds a multiply and the 64-by-32 divider, which
// retires two quotient bits per cycle. A finished result waits in the
// output register while the next request is accepted. Configuration
// writes are always taken; write them only while the block is idle. Table
// entries are undefined until loaded.

module inverse_cdf_interpolating_lookup import icdf_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // Request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // entry_index[7:0], entry_cdf[39:8], entry_value[71:40], query_cdf[103:72]
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  wire logic [0:0]            s_axis_tuser,
    // Result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // value_out[31:0], lower_index[39:32]
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]        m_axis_tuser
);

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic [VALUE_W-1:0] value_out;
    logic [INDEX_W-1:0] lower_index;
    t_status            status;

    assign o_cfg_ready = 1'b1;

    icdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    icdf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (s_axis_tuser[0]),
        .i_entry_index (s_axis_tdata[S_IDX_LSB +: INDEX_W]),
        .i_entry_cdf   (s_axis_tdata[S_ECDF_LSB +: CDF_W]),
        .i_entry_value (s_axis_tdata[S_EVAL_LSB +: VALUE_W]),
        .i_query_cdf   (s_axis_tdata[S_QCDF_LSB +: CDF_W]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_value_out   (value_out),
        .o_lower_index (lower_index),
        .o_status      (status)
    );

    // Pack the result, padding to whole bytes
    assign m_axis_tdata = M_TDATA_W'({lower_index, value_out});
    assign m_axis_tuser = status;

endmodule

`default_nettype wire

### design/icdf_div.sv
`default_nettype none

module icdf_div import icdf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [PROD_W-1:0]  i_dividend,
    input  wire logic [CDF_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic [PROD_W-1:0]       o_quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [CDF_W-1:0]   r_rem;
    logic [PROD_W-1:0]  r_quo;
    logic [CDF_W-1:0]   r_div;
    logic [CDF_W-1:0]   n_rem;
    logic [PROD_W-1:0]  n_quo;

    // Restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        logic [CDF_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int b = 0; b < DIV_BITS; b++) begin
            trial = {n_rem, n_quo[PROD_W-1]};
            n_quo = {n_quo[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem    = CDF_W'(trial - {1'b0, r_div});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[CDF_W-1:0];
            end
        end
    end

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and shifting dividend/quotient word
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### design/icdf_dp.sv
`default_nettype none

module icdf_dp import icdf_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_mode,
    input  wire logic [INDEX_W-1:0]    i_entry_index,
    input  wire logic [CDF_W-1:0]      i_entry_cdf,
    input  wire logic [VALUE_W-1:0]    i_entry_value,
    input  wire logic [CDF_W-1:0]      i_query_cdf,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [VALUE_W-1:0]         o_value_out,
    output logic [INDEX_W-1:0]         o_lower_index,
    output t_status                    o_status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = (AW + 1 > TABLE_SIZE_W) ? AW + 1 : TABLE_SIZE_W;

    // Configuration
    logic [TABLE_SIZE_W-1:0] r_table_size;
    logic                    r_interp;

    // Captured request
    logic                r_mode;
    logic [INDEX_W-1:0]  r_entry_index;
    logic [CDF_W-1:0]    r_entry_cdf;
    logic [VALUE_W-1:0]  r_entry_value;
    logic [CDF_W-1:0]    r_query;

    // Search and bracketing entries
    logic [AW-1:0]       r_lo;
    logic [AW-1:0]       r_hi;
    logic [CDF_W-1:0]    r_c_lo;
    logic [CDF_W-1:0]    r_c_hi;
    logic [VALUE_W-1:0]  r_v_lo;
    logic [VALUE_W-1:0]  r_v_hi;

    // Arithmetic
    logic [VALUE_W-1:0]  r_dv;
    logic [CDF_W-1:0]    r_dq;
    logic [CDF_W-1:0]    r_dc;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   div_quo;
    logic                div_done;

    // Table memories
    logic [CDF_W-1:0]    r_cdf_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]  r_val_mem [TABLE_DEPTH];
    logic [CDF_W-1:0]    r_rd_cdf;
    logic [VALUE_W-1:0]  r_rd_val;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_ok;

    // Result
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_value_out;
    logic [INDEX_W-1:0]  r_lower_index;
    t_status             r_status;
    logic [VALUE_W-1:0]  fin_value;
    logic [INDEX_W-1:0]  fin_index;
    t_status             fin_status;

    logic [AW-1:0]       mid;
    logic [SW-1:0]       ts_ext;
    logic [SW-1:0]       n_use;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
            r_interp     <= INTERP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TABLE_SIZE:  r_table_size <= i_cfg_data[TABLE_SIZE_W-1:0];
                CFG_INTERPOLATE: r_interp     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the entry count into 2..TABLE_DEPTH
    always_comb begin
        ts_ext = SW'(r_table_size);
        if (ts_ext < SW'(2)) begin
            n_use = SW'(2);
        end else if (ts_ext > SW'(TABLE_DEPTH)) begin
            n_use = SW'(TABLE_DEPTH);
        end else begin
            n_use = ts_ext;
        end
    end

    assign mid = AW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);

    // Capture the request and run the search bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode        <= i_mode;
            r_entry_index <= i_entry_index;
            r_entry_cdf   <= i_entry_cdf;
            r_entry_value <= i_entry_value;
            r_query       <= i_query_cdf;
            r_lo          <= '0;
            r_hi          <= AW'(n_use - SW'(1));
        end else if (i_cmd.search_cmp) begin
            if (r_rd_cdf > r_query) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid;
            end
        end
    end

    // Memory address select
    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_MID: rd_addr = mid;
            ADDR_LO:  rd_addr = r_lo;
            ADDR_HI:  rd_addr = r_hi;
            default:  rd_addr = r_lo;
        endcase
    end

    assign wr_ok   = 32'(r_entry_index) < 32'(TABLE_DEPTH);
    assign wr_addr = AW'(r_entry_index);

    // Table memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write && wr_ok) begin
            r_cdf_mem[wr_addr] <= r_entry_cdf;
            r_val_mem[wr_addr] <= r_entry_value;
        end
        r_rd_cdf <= r_cdf_mem[rd_addr];
        r_rd_val <= r_val_mem[rd_addr];
    end

    // Hold the bracketing entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_lo) begin
            r_c_lo <= r_rd_cdf;
            r_v_lo <= r_rd_val;
        end
        if (i_cmd.cap_hi) begin
            r_c_hi <= r_rd_cdf;
            r_v_hi <= r_rd_val;
        end
    end

    // Magnitudes of the three differences, the combined sign, and the value-by-query product
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_dv  <= (r_v_hi >= r_v_lo) ? (r_v_hi - r_v_lo) : (r_v_lo - r_v_hi);
            r_dq  <= (r_query >= r_c_lo) ? (r_query - r_c_lo) : (r_c_lo - r_query);
            r_dc  <= (r_c_hi >= r_c_lo) ? (r_c_hi - r_c_lo) : (r_c_lo - r_c_hi);
            r_neg <= (r_v_hi < r_v_lo) ^ (r_query < r_c_lo) ^ (r_c_hi < r_c_lo);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_dv) * PROD_W'(r_dq);
        end
    end

    icdf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dc),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Result selection and saturation
    always_comb begin
        logic [PROD_W:0] sum;
        sum = {1'b0, PROD_W'(r_v_lo)} + {1'b0, div_quo};
        fin_index = INDEX_W'(r_lo);
        if (r_mode == MODE_LOAD) begin
            fin_value  = '0;
            fin_index  = '0;
            fin_status = ST_OK;
        end else if (!r_interp) begin
            fin_value  = r_v_lo;
            fin_status = ST_OK;
        end else if (r_c_hi == r_c_lo) begin
            fin_value  = r_v_lo;
            fin_status = ST_EQUAL;
        end else if (r_neg) begin
            if (div_quo > PROD_W'(r_v_lo)) begin
                fin_value  = '0;
                fin_status = ST_SAT;
            end else begin
                fin_value  = r_v_lo - div_quo[VALUE_W-1:0];
                fin_status = ST_OK;
            end
        end else begin
            if (|sum[PROD_W:VALUE_W]) begin
                fin_value  = '1;
                fin_status = ST_SAT;
            end else begin
                fin_value  = sum[VALUE_W-1:0];
                fin_status = ST_OK;
            end
        end
    end

    // Stage the finished result, then hand it to the output register
    logic [VALUE_W-1:0] r_fin_value;
    logic [INDEX_W-1:0] r_fin_index;
    t_status            r_fin_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_fin_value  <= fin_value;
            r_fin_index  <= fin_index;
            r_fin_status <= fin_status;
        end
        if (i_cmd.push) begin
            r_value_out   <= r_fin_value;
            r_lower_index <= r_fin_index;
            r_status      <= r_fin_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.in_query    = (i_mode == MODE_QUERY);
    assign o_sts.search_more = (r_hi - r_lo) > AW'(1);
    assign o_sts.use_math    = r_interp && (r_c_hi != r_c_lo);
    assign o_sts.div_done    = div_done;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_value_out   = r_value_out;
    assign o_lower_index = r_lower_index;
    assign o_status      = r_status;

endmodule

`default_nettype wire

### design/icdf_ctrl.sv
`default_nettype none

module icdf_ctrl import icdf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_query ? S_SEARCH_RD : S_LOAD;
                end
            end
            S_LOAD:       n_state = S_FIN;
            S_SEARCH_RD:  n_state = i_sts.search_more ? S_SEARCH_CMP : S_RD_HI;
            S_SEARCH_CMP: n_state = S_SEARCH_RD;
            S_RD_HI:      n_state = S_CAP_HI;
            S_CAP_HI:     n_state = S_DIFF;
            S_DIFF:       n_state = i_sts.use_math ? S_MUL : S_FIN;
            S_MUL:        n_state = S_DSTART;
            S_DSTART:     n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:        n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:      n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = ADDR_LO;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_LOAD:       o_cmd.mem_write = 1'b1;
            S_SEARCH_RD:  o_cmd.addr_sel = i_sts.search_more ? ADDR_MID : ADDR_LO;
            S_SEARCH_CMP: o_cmd.search_cmp = 1'b1;
            S_RD_HI: begin
                o_cmd.addr_sel = ADDR_HI;
                o_cmd.cap_lo   = 1'b1;
            end
            S_CAP_HI:     o_cmd.cap_hi = 1'b1;
            S_DIFF:       o_cmd.diff = 1'b1;
            S_MUL:        o_cmd.mul = 1'b1;
            S_DSTART:     o_cmd.div_start = 1'b1;
            S_DIV:        ;
            S_FIN:        o_cmd.finish = 1'b1;
            S_OUT:        o_cmd.push = i_sts.out_free;
            default:      ;
        endcase
    end

endmodule

`default_nettype wire

### design/icdf_checker.sv
`default_nettype none

`include "inverse_cdf_interpolating_lookup_defines.svh"

module icdf_checker import icdf_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [STATUS_W-1:0]  m_axis_tuser
);

    // A stalled result holds its payload
    `ICDF_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // One request in flight: acceptance drops ready
    `ICDF_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A saturated result sits at one of the two rails
    `ICDF_ASSERT_NOW(a_sat_rails, m_axis_tvalid && (m_axis_tuser == ST_SAT), (m_axis_tdata[VALUE_W-1:0] == '0) || (m_axis_tdata[VALUE_W-1:0] == '1))

    // Status only carries defined codes
    `ICDF_ASSERT_NOW(a_status_code, m_axis_tvalid, (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_EQUAL) || (m_axis_tuser == ST_SAT))

endmodule

bind inverse_cdf_interpolating_lookup icdf_checker u_icdf_checker (.*);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import icdf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [CDF_W-1:0] CDF_ONE = 32'h8000_0000;
    // index that decodes to no register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(15);
    localparam int NUM_PHASES = 13;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] idx;
        logic [CDF_W-1:0]   ecdf;
        logic [VALUE_W-1:0] entry_val;
        logic [CDF_W-1:0]   qcdf;
    } t_lookup_req;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] lidx;
        t_status            status;
    } t_lookup_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // requests waiting for the driver, results waiting for the DUT
    t_lookup_req    pending[$];
    t_lookup_result lookup_q[$];
    t_lookup_req    cur_req;
    t_lookup_result want_res;

    // lookup table as the predictor sees it, updated at acceptance
    logic [CDF_W-1:0]   pred_cdf [TABLE_DEPTH_DEF];
    logic [VALUE_W-1:0] pred_val [TABLE_DEPTH_DEF];
    logic [TABLE_SIZE_W-1:0] cfg_size = TABLE_SIZE_RST;
    logic                    cfg_interp = INTERP_RST;

    // CDF points as the generator has queued them
    logic [CDF_W-1:0] gen_cdf [TABLE_DEPTH_DEF];

    int unsigned phase_size [NUM_PHASES] = '{0, 1, 3, 256, 5, 16, 17, 511, 9, 100, 2, 33, 2};
    bit          phase_interp [NUM_PHASES] = '{1, 0, 1, 1, 1, 0, 1, 1, 1, 1, 0, 1, 1};
    int          idle_phase = 0;
    int          n_fail = 0;
    int unsigned cycle_cnt = 0;

    inverse_cdf_interpolating_lookup u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clamp the table size register to the entries actually searched
    function automatic int unsigned eff_entries(input int unsigned size);
        if (size < 2) return 2;
        if (size > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
        return size;
    endfunction

    // Apply one request to the table copy and compute its result
    function automatic t_lookup_result predict_lookup(input t_lookup_req r);
        t_lookup_result res;
        int unsigned n, lo, hi, mid;
        logic [CDF_W-1:0] c_lo, c_hi;
        logic [VALUE_W-1:0] v_lo, v_hi;
        logic [PROD_W-1:0] dv, dq, dc, quo;
        logic neg;
        res = '0;
        res.status = ST_OK;
        if (r.mode == MODE_LOAD) begin
            pred_cdf[r.idx] = r.ecdf;
            pred_val[r.idx] = r.entry_val;
            return res;
        end
        // binary search; a tie moves the lower bound up
        n = eff_entries(cfg_size);
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (pred_cdf[mid] > r.qcdf) hi = mid;
            else lo = mid;
        end
        c_lo = pred_cdf[lo];
        c_hi = pred_cdf[hi];
        v_lo = pred_val[lo];
        v_hi = pred_val[hi];
        res.lidx = lo[INDEX_W-1:0];
        if (!cfg_interp) begin
            res.value = v_lo;
        end else if (c_hi == c_lo) begin
            res.value = v_lo;
            res.status = ST_EQUAL;
        end else begin
            // sign-magnitude interpolation, quotient truncated toward zero
            neg = 1'b0;
            if (v_hi >= v_lo) begin
                dv = {32'd0, v_hi - v_lo};
            end else begin
                dv = {32'd0, v_lo - v_hi};
                neg = ~neg;
            end
            if (r.qcdf >= c_lo) begin
                dq = {32'd0, r.qcdf - c_lo};
            end else begin
                dq = {32'd0, c_lo - r.qcdf};
                neg = ~neg;
            end
            if (c_hi >= c_lo) begin
                dc = {32'd0, c_hi - c_lo};
            end else begin
                dc = {32'd0, c_lo - c_hi};
                neg = ~neg;
            end
            quo = (dv * dq) / dc;
            if (quo == 0) begin
                res.value = v_lo;
            end else if (neg) begin
                if (quo > {32'd0, v_lo}) begin
                    res.value = '0;
                    res.status = ST_SAT;
                end else begin
                    res.value = v_lo - quo[VALUE_W-1:0];
                end
            end else if (quo > 64'h0000_0000_FFFF_FFFF - {32'd0, v_lo}) begin
                res.value = 32'hFFFF_FFFF;
                res.status = ST_SAT;
            end else begin
                res.value = v_lo + quo[VALUE_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic push_load(input logic [INDEX_W-1:0] idx, input logic [CDF_W-1:0] cdf,
                             input logic [VALUE_W-1:0] val);
        t_lookup_req r;
        r.mode = MODE_LOAD;
        r.idx = idx;
        r.ecdf = cdf;
        r.entry_val = val;
        r.qcdf = $urandom_range(CDF_ONE);
        pending.push_back(r);
        gen_cdf[idx] = cdf;
    endtask

    // Unused load fields carry random noise
    task automatic push_query(input logic [CDF_W-1:0] q);
        t_lookup_req r;
        r.mode = MODE_QUERY;
        r.idx = INDEX_W'($urandom_range(255));
        r.ecdf = $urandom_range(CDF_ONE);
        r.entry_val = $urandom;
        r.qcdf = q;
        pending.push_back(r);
    endtask

    // Hold until every queued request has produced its result
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid || lookup_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TABLE_SIZE: cfg_size = data;
            CFG_INTERPOLATE: cfg_interp = data[0];
            default: ;
        endcase
    endtask

    // Fill entries 0..n-1: mostly ascending with some ties, now and then unordered
    task automatic load_table(input int unsigned n);
        logic [CDF_W-1:0] c, step;
        logic [CDF_W:0] nxt;
        logic [VALUE_W-1:0] v;
        bit unordered;
        step = CDF_ONE / n;
        unordered = ($urandom_range(4) == 0);
        c = $urandom_range(step);
        v = $urandom;
        for (int i = 0; i < n; i++) begin
            if (unordered) begin
                push_load(INDEX_W'(i), $urandom_range(CDF_ONE), $urandom);
            end else begin
                push_load(INDEX_W'(i), c, v);
                if ($urandom_range(7) != 0) begin
                    nxt = {1'b0, c} + {1'b0, $urandom_range(2 * step, 1)};
                    c = (nxt > {1'b0, CDF_ONE}) ? CDF_ONE : nxt[CDF_W-1:0];
                end
                if ($urandom_range(7) != 0) v = $urandom;
            end
        end
    endtask

    // Mostly queries aimed at table points and their neighbors, some reloads
    task automatic run_random(input int unsigned n, input int count);
        int sel, j;
        logic [CDF_W-1:0] q;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            j = $urandom_range(n - 1);
            if (sel < 4) begin
                push_load(INDEX_W'($urandom_range(255)), $urandom_range(CDF_ONE), $urandom);
            end else if (sel < 14) begin
                push_load(INDEX_W'(j), (sel < 9) ? gen_cdf[j] : $urandom_range(CDF_ONE),
                          $urandom);
            end else begin
                case ($urandom_range(9))
                    0: q = '0;
                    1: q = CDF_ONE;
                    2, 3, 4: q = gen_cdf[j];
                    5: q = (gen_cdf[j] < CDF_ONE) ? gen_cdf[j] + 1 : gen_cdf[j];
                    6: q = (gen_cdf[j] != 0) ? gen_cdf[j] - 1 : gen_cdf[j];
                    default: q = $urandom_range(CDF_ONE);
                endcase
                push_query(q);
            end
            if ($urandom_range(49) == 0) wait_drained();
        end
    endtask

    // Driver: score the request taken at this edge, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lookup_q.push_back(predict_lookup(cur_req));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending.size() != 0 &&
                    $urandom_range(99) >= ((idle_phase == 0) ? 13 : (idle_phase == 1) ? 48 : 0)) begin
                    cur_req = pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {cur_req.qcdf, cur_req.entry_val, cur_req.ecdf, cur_req.idx};
                    s_axis_tuser <= cur_req.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (lookup_q.size() == 0) begin
                    if (n_fail < 100)
                        $display("%0t: result with no request pending: tdata %h tuser %h",
                                 $time, m_axis_tdata, m_axis_tuser);
                    n_fail++;
                end else begin
                    want_res = lookup_q.pop_front();
                    if (m_axis_tdata[M_VAL_LSB +: VALUE_W] !== want_res.value) begin
                        if (n_fail < 100)
                            $display("%0t: value_out expected %h actual %h", $time,
                                     want_res.value, m_axis_tdata[M_VAL_LSB +: VALUE_W]);
                        n_fail++;
                    end
                    if (m_axis_tdata[M_LIDX_LSB +: INDEX_W] !== want_res.lidx) begin
                        if (n_fail < 100)
                            $display("%0t: lower_index expected %0d actual %0d", $time,
                                     want_res.lidx, m_axis_tdata[M_LIDX_LSB +: INDEX_W]);
                        n_fail++;
                    end
                    if (m_axis_tuser !== want_res.status) begin
                        if (n_fail < 100)
                            $display("%0t: status expected %0d actual %0d", $time,
                                     want_res.status, m_axis_tuser);
                        n_fail++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= ((idle_phase == 0) ? 48 :
                                                     (idle_phase == 1) ? 13 : 0));
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-span two-entry table at the reset settings
        push_load(0, '0, '0);
        push_load(1, CDF_ONE, 32'hFFFF_FFFF);
        push_query('0);
        push_query(CDF_ONE);
        push_query(32'h4000_0000);
        // equal bracketing points
        push_load(1, '0, 32'h1234_5678);
        push_query(32'h0000_1234);
        // extrapolate below the first point, then just inside
        push_load(0, 32'h4000_0000, 100);
        push_load(1, CDF_ONE, 32'hFFFF_FFFF);
        push_query('0);
        push_query(32'h4000_0001);
        // extrapolate past the top
        push_load(0, '0, 32'hFFFF_FF00);
        push_load(1, 32'h4000_0000, 32'hFFFF_FFFF);
        push_query(CDF_ONE);
        // falling values, and a step too small to move the result
        push_load(0, '0, 1000);
        push_load(1, CDF_ONE, '0);
        push_query(32'h4000_0000);
        push_query(1);
        // descending points
        push_load(0, CDF_ONE, 5);
        push_load(1, '0, 9);
        push_query(32'h2000_0000);
        push_load(255, CDF_ONE, 32'hFFFF_FFFF);
        wait_drained();
        repeat (8) @(posedge i_clk);
        // lower-value mode
        write_reg(CFG_INTERPOLATE, '0);
        push_query('0);
        push_query(CDF_ONE);

        // sweep table sizes and modes; idling pattern 0 for phases 0-3, 1 for 4-7, 2 for the rest
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            repeat (8) @(posedge i_clk);
            idle_phase = (p < 4) ? 0 : (p < 8) ? 1 : 2;
            write_reg(CFG_TABLE_SIZE, CFG_DATA_W'(phase_size[p]));
            write_reg(CFG_INTERPOLATE, {8'($urandom), phase_interp[p]});
            if (p == 6) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            load_table(eff_entries(phase_size[p]));
            run_random(eff_entries(phase_size[p]), 24);
        end

        wait_drained();
        repeat (80) @(posedge i_clk);
        if (n_fail == 0 && lookup_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/icdf_pkg.sv
design/icdf_div.sv
design/icdf_dp.sv
design/icdf_ctrl.sv
design/inverse_cdf_interpolating_lookup.sv
design/icdf_checker.sv
verif/tb.sv
